// ----- design/ppcw_pkg.sv -----
// Package for the polar pose controller: widths, register indexes, state codes,
// the CORDIC arctangent table and the control struct handed to the datapath units.
// No dependencies.
`timescale 1ns / 1ps

package ppcw_pkg;

  localparam int WP_MAX      = 4;
  localparam int WP_IDX_W    = 2;
  localparam int CNT_W       = 5;
  localparam int CORDIC_STEPS = 16;
  localparam int Z_W         = 21;
  localparam int CA_W        = 32;
  localparam int SQ_W        = 34;
  localparam int ACC_W       = 36;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic signed [Z_W-1:0] PI_Q16 = 21'sd205887;
  localparam logic signed [16:0]    PI_Q12 = 17'sd12868;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_WP0   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_WP1   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_WP2   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_WP3   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_K1    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_K2    = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_K3    = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_THR   = 3'd7;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;
  localparam logic [2:0] ST_ROOT = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  typedef struct packed {
    logic             load;
    logic             step;
    logic [CNT_W-1:0] cnt;
  } unit_ctl_t;

  function automatic logic signed [Z_W-1:0] atan_q16(input logic [3:0] i);
    logic signed [Z_W-1:0] v;
    case (i)
      4'd0:    v = 21'sd51472;
      4'd1:    v = 21'sd30386;
      4'd2:    v = 21'sd16055;
      4'd3:    v = 21'sd8150;
      4'd4:    v = 21'sd4091;
      4'd5:    v = 21'sd2047;
      4'd6:    v = 21'sd1024;
      4'd7:    v = 21'sd512;
      4'd8:    v = 21'sd256;
      4'd9:    v = 21'sd128;
      4'd10:   v = 21'sd64;
      4'd11:   v = 21'sd32;
      4'd12:   v = 21'sd16;
      4'd13:   v = 21'sd8;
      4'd14:   v = 21'sd4;
      default: v = 21'sd2;
    endcase
    return v;
  endfunction

endpackage

// ----- design/ppcw_if.sv -----
// Valid/ready channel interfaces for odometry samples and velocity commands.
// Depends on nothing but plain logic types.
`timescale 1ns / 1ps

interface ppcw_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [14:0] yaw;
  modport source (output valid, pos_x, pos_y, yaw, input ready);
  modport sink   (input valid, pos_x, pos_y, yaw, output ready);
endinterface

interface ppcw_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] lin_vel;
  logic signed [15:0] ang_vel;
  logic        [15:0] distance;
  logic signed [16:0] alpha;
  logic signed [14:0] bearing;
  logic        [1:0]  waypoint_used;
  logic               arrived;
  modport source (output valid, lin_vel, ang_vel, distance, alpha, bearing,
                  waypoint_used, arrived, input ready);
  modport sink   (input valid, lin_vel, ang_vel, distance, alpha, bearing,
                  waypoint_used, arrived, output ready);
endinterface

// ----- design/ppcw_cordic.sv -----
// Vectoring CORDIC, one iteration per step: angle of (-x, -y) in Q.16 radians.
// Depends on ppcw_pkg.
`timescale 1ns / 1ps

module ppcw_cordic
  import ppcw_pkg::*;
(
  input  logic                  clk,
  input  unit_ctl_t             ctl,
  input  logic signed [16:0]    x_i,
  input  logic signed [16:0]    y_i,
  output logic signed [Z_W-1:0] z_o,
  output logic                  origin_o
);

  logic signed [CA_W-1:0] a_r, b_r, da, db;
  logic signed [Z_W-1:0]  z_r, atn;
  logic                   origin_r;
  logic signed [17:0]     na, nb, a0, b0;
  logic signed [Z_W-1:0]  z0;

  always_comb begin
    na = -{x_i[16], x_i};
    nb = -{y_i[16], y_i};
    if (na < 0) begin
      a0 = -na;
      b0 = -nb;
      z0 = (nb >= 0) ? PI_Q16 : -PI_Q16;
    end else begin
      a0 = na;
      b0 = nb;
      z0 = '0;
    end
    da  = b_r >>> ctl.cnt[3:0];
    db  = a_r >>> ctl.cnt[3:0];
    atn = atan_q16(ctl.cnt[3:0]);
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a_r      <= {{(CA_W-30){a0[17]}}, a0, 12'b0};
      b_r      <= {{(CA_W-30){b0[17]}}, b0, 12'b0};
      z_r      <= z0;
      origin_r <= (x_i == '0) && (y_i == '0);
    end else if (ctl.step) begin
      // rotate toward the positive x axis
      if (!b_r[CA_W-1]) begin
        a_r <= a_r + da;
        b_r <= b_r - db;
        z_r <= z_r + atn;
      end else begin
        a_r <= a_r - da;
        b_r <= b_r + db;
        z_r <= z_r - atn;
      end
    end
  end

  assign z_o      = z_r;
  assign origin_o = origin_r;

endmodule

// ----- design/ppcw_norm.sv -----
// Distance unit: bit-serial squares of |x| and |y|, then a restoring square root
// producing one root bit per step. Depends on ppcw_pkg.
`timescale 1ns / 1ps

module ppcw_norm
  import ppcw_pkg::*;
(
  input  logic               clk,
  input  unit_ctl_t          sq_ctl,
  input  unit_ctl_t          rt_ctl,
  input  logic signed [16:0] x_i,
  input  logic signed [16:0] y_i,
  output logic        [15:0] rho_o
);

  logic [SQ_W-1:0] mc_x_r, mc_y_r, sq_r, n_r, r_r, bit_r;
  logic [16:0]     mp_x_r, mp_y_r, ax, ay;
  logic [SQ_W:0]   trial;

  assign ax    = x_i[16] ? 17'(-x_i) : 17'(x_i);
  assign ay    = y_i[16] ? 17'(-y_i) : 17'(y_i);
  assign trial = {1'b0, r_r} + {1'b0, bit_r};

  always_ff @(posedge clk) begin
    if (sq_ctl.load) begin
      mc_x_r <= {{(SQ_W-17){1'b0}}, ax};
      mc_y_r <= {{(SQ_W-17){1'b0}}, ay};
      mp_x_r <= ax;
      mp_y_r <= ay;
      sq_r   <= '0;
    end else if (sq_ctl.step) begin
      sq_r   <= sq_r + (mp_x_r[0] ? mc_x_r : '0) + (mp_y_r[0] ? mc_y_r : '0);
      mc_x_r <= mc_x_r << 1;
      mc_y_r <= mc_y_r << 1;
      mp_x_r <= mp_x_r >> 1;
      mp_y_r <= mp_y_r >> 1;
    end
    if (rt_ctl.load) begin
      n_r   <= sq_r;
      r_r   <= '0;
      bit_r <= {2'b01, {(SQ_W-2){1'b0}}};
    end else if (rt_ctl.step) begin
      if ({1'b0, n_r} >= trial) begin
        n_r <= n_r - trial[SQ_W-1:0];
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign rho_o = (r_r > SQ_W'(16'hFFFF)) ? 16'hFFFF : r_r[15:0];

endmodule

// ----- design/ppcw_mac.sv -----
// Serial gain multiplier: one gain bit per step for k1*rho and k2*alpha + k3*beta,
// with rounding and 16-bit saturation on the outputs. Depends on ppcw_pkg.
`timescale 1ns / 1ps

module ppcw_mac
  import ppcw_pkg::*;
(
  input  logic               clk,
  input  unit_ctl_t          ctl,
  input  logic        [15:0] rho_i,
  input  logic signed [16:0] alpha_i,
  input  logic signed [14:0] beta_i,
  input  logic signed [15:0] k1_i,
  input  logic signed [15:0] k2_i,
  input  logic signed [15:0] k3_i,
  output logic signed [15:0] lin_o,
  output logic signed [15:0] ang_o
);

  logic signed [ACC_W-1:0] op_r_r, op_a_r, op_b_r, acc_l_r, acc_a_r;
  logic signed [ACC_W-1:0] t_r, t_a, t_b;
  logic signed [ACC_W-1:0] rl, ra;
  logic signed [ACC_W-13:0] sl, sa;
  logic                     last;

  function automatic logic signed [15:0] sat16(input logic signed [ACC_W-13:0] v);
    if (v > 32767)       return 16'sh7FFF;
    else if (v < -32768) return 16'sh8000;
    else                 return v[15:0];
  endfunction

  always_comb begin
    last = (ctl.cnt[3:0] == 4'd15);
    t_r  = k1_i[ctl.cnt[3:0]] ? (last ? -op_r_r : op_r_r) : '0;
    t_a  = k2_i[ctl.cnt[3:0]] ? (last ? -op_a_r : op_a_r) : '0;
    t_b  = k3_i[ctl.cnt[3:0]] ? (last ? -op_b_r : op_b_r) : '0;
    rl   = acc_l_r + ACC_W'(2048);
    ra   = acc_a_r + ACC_W'(2048);
    sl   = rl[ACC_W-1:12];
    sa   = ra[ACC_W-1:12];
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op_r_r  <= {{(ACC_W-16){1'b0}}, rho_i};
      op_a_r  <= {{(ACC_W-17){alpha_i[16]}}, alpha_i};
      op_b_r  <= {{(ACC_W-15){beta_i[14]}}, beta_i};
      acc_l_r <= '0;
      acc_a_r <= '0;
    end else if (ctl.step) begin
      acc_l_r <= acc_l_r + t_r;
      acc_a_r <= acc_a_r + t_a + t_b;
      op_r_r  <= op_r_r <<< 1;
      op_a_r  <= op_a_r <<< 1;
      op_b_r  <= op_b_r <<< 1;
    end
  end

  assign lin_o = sat16(sl);
  assign ang_o = sat16(sa);

endmodule

// ----- design/polar_pose_control_waypoints.sv -----
// Top level of the polar pose controller; instantiates ppcw_cordic, ppcw_norm and
// ppcw_mac, uses ppcw_pkg and the channel interfaces in ppcw_if.
`timescale 1ns / 1ps

// Polar pose controller with a ring of waypoints. Each odometry transfer
// (pos_x, pos_y, yaw) has the current waypoint offset added, then the block
// forms distance rho, bearing beta = -atan2(-y,-x) and heading error
// alpha = -beta - yaw, and returns lin_vel = k1*rho and ang_vel = k2*alpha +
// k3*beta, both rounded and saturated. When rho is below the arrival threshold
// the waypoint index advances, wrapping after WAYPOINT_COUNT entries. One sample
// is processed at a time: bit-serial squaring (CORDIC running alongside, one
// iteration per cycle), then the one-bit-per-cycle square root, the
// one-gain-bit-per-cycle multiply and a final rounding state; a new sample is
// taken the cycle after the result is loaded into the output register. The
// output register holds a result until it is taken. Configuration writes are
// meant for idle periods only; writes to indexes beyond the list are dropped.
module polar_pose_control_waypoints
  import ppcw_pkg::*;
#(
  parameter int WAYPOINT_COUNT = WP_MAX
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ppcw_in_if.sink               in_chan,
  ppcw_out_if.source            out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // configuration
  logic [31:0]        wp_r [WAYPOINT_COUNT];
  logic signed [15:0] k1_r, k2_r, k3_r;
  logic [15:0]        thr_r;

  // sequencer
  logic [2:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [WP_IDX_W-1:0] idx_r, idx_nxt, used_r;
  logic signed [14:0]  yaw_r;
  logic signed [16:0]  x_c, y_c, alpha_r;
  logic signed [14:0]  bearing_r;
  logic                in_fire, out_load;

  // output register
  logic                out_valid_r;
  logic signed [15:0]  lin_o_r, ang_o_r;
  logic [15:0]         dist_o_r;
  logic signed [16:0]  alpha_o_r;
  logic signed [14:0]  bear_o_r;
  logic [WP_IDX_W-1:0] used_o_r;
  logic                arr_o_r;

  unit_ctl_t          cor_ctl, sq_ctl, rt_ctl, mac_ctl;
  logic signed [Z_W-1:0] z;
  logic                origin;
  logic [15:0]         rho;
  logic signed [15:0]  lin, ang;
  logic signed [16:0]  zr, zc;
  logic signed [Z_W-1:0] zs;
  logic                arrived;
  logic [31:0]         wp_sel;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign out_load      = (state_r == ST_FIN) && (!out_valid_r || out_chan.ready);
  assign arrived       = (rho < thr_r);

  // add the waypoint offset to the sample
  assign wp_sel = wp_r[idx_r];
  assign x_c = {wp_sel[31], wp_sel[31:16]} + {in_chan.pos_x[15], in_chan.pos_x};
  assign y_c = {wp_sel[15], wp_sel[15:0]}  + {in_chan.pos_y[15], in_chan.pos_y};

  // round the Q.16 angle to Q3.12 and clamp to +-pi (zero at the origin)
  always_comb begin
    zs = z + Z_W'(8);
    zr = zs[Z_W-1:4];
    if (origin)           zc = '0;
    else if (zr > PI_Q12)  zc = PI_Q12;
    else if (zr < -PI_Q12) zc = -PI_Q12;
    else                   zc = zr;
  end

  // unit control: load on entry, then one digit per cycle
  always_comb begin
    sq_ctl  = '{load: in_fire, step: (state_r == ST_SQ), cnt: cnt_r};
    cor_ctl = '{load: in_fire, step: (state_r == ST_SQ) && (cnt_r < CNT_W'(CORDIC_STEPS)),
                cnt: cnt_r};
    rt_ctl  = '{load: (state_r == ST_ROOT) && (cnt_r == '0),
                step: (state_r == ST_ROOT) && (cnt_r != '0), cnt: cnt_r};
    mac_ctl = '{load: (state_r == ST_MUL) && (cnt_r == '0),
                step: (state_r == ST_MUL) && (cnt_r != '0), cnt: cnt_r - CNT_W'(1)};
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + CNT_W'(1);
    idx_nxt   = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_fire) state_nxt = ST_SQ;
      end
      ST_SQ: begin
        if (cnt_r == CNT_W'(16)) begin
          state_nxt = ST_ROOT;
          cnt_nxt   = '0;
        end
      end
      ST_ROOT: begin
        if (cnt_r == CNT_W'(17)) begin
          state_nxt = ST_MUL;
          cnt_nxt   = '0;
        end
      end
      ST_MUL: begin
        if (cnt_r == CNT_W'(16)) begin
          state_nxt = ST_FIN;
          cnt_nxt   = '0;
        end
      end
      ST_FIN: begin
        cnt_nxt = '0;
        if (out_load) begin
          state_nxt = ST_IDLE;
          // advance the waypoint on arrival
          if (arrived) begin
            if (32'(used_r) + 32'd1 >= 32'(WAYPOINT_COUNT)) idx_nxt = '0;
            else idx_nxt = used_r + WP_IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      k1_r        <= 16'sd1024;
      k2_r        <= 16'sd3686;
      k3_r        <= -16'sd1229;
      thr_r       <= 16'd8;
      for (int i = 0; i < WAYPOINT_COUNT; i++) begin
        wp_r[i] <= {16'(-(i + 1) * 256), 16'h0000};
      end
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      if (out_load)                               out_valid_r <= 1'b1;
      else if (out_chan.ready)                    out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_WP0, REG_WP1, REG_WP2, REG_WP3: begin
            for (int i = 0; i < WAYPOINT_COUNT; i++) begin
              if (cfg_addr == CFG_ADDR_W'(i)) wp_r[i] <= cfg_wdata;
            end
          end
          REG_K1:  k1_r  <= cfg_wdata[15:0];
          REG_K2:  k2_r  <= cfg_wdata[15:0];
          REG_K3:  k3_r  <= cfg_wdata[15:0];
          REG_THR: thr_r <= cfg_wdata[15:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      yaw_r  <= in_chan.yaw;
      used_r <= idx_r;
    end
    if (rt_ctl.load) begin
      bearing_r <= 15'(-zc);
      alpha_r   <= zc - {{2{yaw_r[14]}}, yaw_r};
    end
    if (out_load) begin
      lin_o_r   <= lin;
      ang_o_r   <= ang;
      dist_o_r  <= rho;
      alpha_o_r <= alpha_r;
      bear_o_r  <= bearing_r;
      used_o_r  <= used_r;
      arr_o_r   <= arrived;
    end
  end

  ppcw_cordic u_cordic (
    .clk     (clk),
    .ctl     (cor_ctl),
    .x_i     (x_c),
    .y_i     (y_c),
    .z_o     (z),
    .origin_o(origin)
  );

  ppcw_norm u_norm (
    .clk   (clk),
    .sq_ctl(sq_ctl),
    .rt_ctl(rt_ctl),
    .x_i   (x_c),
    .y_i   (y_c),
    .rho_o (rho)
  );

  ppcw_mac u_mac (
    .clk    (clk),
    .ctl    (mac_ctl),
    .rho_i  (rho),
    .alpha_i(alpha_r),
    .beta_i (bearing_r),
    .k1_i   (k1_r),
    .k2_i   (k2_r),
    .k3_i   (k3_r),
    .lin_o  (lin),
    .ang_o  (ang)
  );

  assign out_chan.valid         = out_valid_r;
  assign out_chan.lin_vel       = lin_o_r;
  assign out_chan.ang_vel       = ang_o_r;
  assign out_chan.distance      = dist_o_r;
  assign out_chan.alpha         = alpha_o_r;
  assign out_chan.bearing       = bear_o_r;
  assign out_chan.waypoint_used = used_o_r;
  assign out_chan.arrived       = arr_o_r;

`ifndef ASSERT_OFF
  a_busy_after_fire: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_SQ))
    else $error("sequencer did not start after sample transfer");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(idx_r) < 32'(WAYPOINT_COUNT))
    else $error("waypoint index out of range");

  a_idx_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_load && arrived) |=> $stable(idx_r))
    else $error("waypoint index moved without arrival");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQ || state_r == ST_MUL) |-> (cnt_r <= CNT_W'(16)))
    else $error("digit counter overran");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("result load lost");
`endif

endmodule

// ----- tb/tb_polar_pose_control_waypoints.sv -----
// Self-checking bench for the polar pose controller with a ring of waypoints.
// Drives odometry samples into the controller and checks each velocity command against
// a predictor built into this bench. Depends on ppcw_pkg, ppcw_if and the RTL top level.
`timescale 1ns / 1ps

module tb_polar_pose_control_waypoints;
  import ppcw_pkg::*;

  typedef struct {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [14:0] yaw;
  } odom_t;

  typedef struct {
    logic signed [15:0] lin_vel;
    logic signed [15:0] ang_vel;
    logic        [15:0] distance;
    logic signed [16:0] alpha;
    logic signed [14:0] bearing;
    logic        [1:0]  waypoint_used;
    logic               arrived;
  } command_t;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 80;
  localparam int HOLD_CYCLES    = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = REG_WP0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  ppcw_in_if  in_chan ();
  ppcw_out_if out_chan ();

  polar_pose_control_waypoints DUT (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan.sink), .out_chan(out_chan.source),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // shadow copy of the controller's registers and state
  logic [31:0] wp_reg [4];
  logic [15:0] k_dist, k_alpha, k_beta, arrive_thr;
  logic [1:0]  wp_index;

  odom_t    sample_q [$];
  command_t command_q [$];
  int       fail_count = 0;
  int       idle_cycles = 0;
  bit       hold_off = 1'b0;

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // CORDIC vectoring angle of (a, b), Q3.12, clamped to +-pi
  function automatic longint cordic_angle(longint a, longint b);
    longint z, da, db;
    longint atan_tab [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                              256, 128, 64, 32, 16, 8, 4, 2};
    z = 0;
    if (a == 0 && b == 0) return 0;
    if (a < 0) begin
      z = (b >= 0) ? 205887 : -205887;
      a = -a;
      b = -b;
    end
    a = a * 4096;
    b = b * 4096;
    for (int i = 0; i < 16; i++) begin
      da = b >>> i;
      db = a >>> i;
      if (b >= 0) begin
        a += da; b -= db; z += atan_tab[i];
      end else begin
        a -= da; b += db; z -= atan_tab[i];
      end
    end
    z = (z + 8) >>> 4;
    if (z > 12868) z = 12868;
    if (z < -12868) z = -12868;
    return z;
  endfunction

  function automatic longint int_sqrt(longint n);
    longint r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b; r = (r >>> 1) + b;
      end else r = r >>> 1;
      b = b >>> 2;
    end
    return r;
  endfunction

  // compute the command for one sample and advance the waypoint index on arrival
  function automatic command_t predict_command(odom_t s);
    command_t c;
    longint x, y, rho, beta, alpha;
    x = longint'($signed(wp_reg[wp_index][31:16])) + longint'(s.pos_x);
    y = longint'($signed(wp_reg[wp_index][15:0])) + longint'(s.pos_y);
    rho = int_sqrt(x * x + y * y);
    if (rho > 65535) rho = 65535;
    beta = -cordic_angle(-x, -y);
    alpha = -beta - longint'(s.yaw);
    c.lin_vel = 16'(sat16((longint'($signed(k_dist)) * rho + 2048) >>> 12));
    c.ang_vel = 16'(sat16((longint'($signed(k_alpha)) * alpha +
                           longint'($signed(k_beta)) * beta + 2048) >>> 12));
    c.distance = 16'(rho);
    c.alpha = 17'(alpha);
    c.bearing = 15'(beta);
    c.waypoint_used = wp_index;
    c.arrived = (rho < longint'(arrive_thr));
    if (c.arrived) wp_index = wp_index + 2'd1;
    return c;
  endfunction

  // transfers seen at the last rising edge, for the falling-edge drivers
  bit in_taken = 1'b0;
  bit out_taken = 1'b0;
  always @(posedge clk) begin
    in_taken = in_chan.valid && in_chan.ready;
    out_taken = out_chan.valid && out_chan.ready;
  end

  // Driver: offer each item until the transfer happens, then idle for a random gap.
  int  send_gap = 0;
  bit  send_busy = 1'b0;
  initial begin
    in_chan.valid = 1'b0;
    in_chan.pos_x = '0;
    in_chan.pos_y = '0;
    in_chan.yaw = '0;
    out_chan.ready = 1'b0;
  end

  always @(negedge clk) begin
    if (send_busy && !in_taken) begin
      // hold the current item
    end else if (send_gap > 0) begin
      in_chan.valid <= 1'b0;
      send_busy = 1'b0;
      send_gap--;
    end else if (sample_q.size() > 0 && rst_n) begin
      odom_t s;
      s = sample_q.pop_front();
      in_chan.pos_x <= s.pos_x;
      in_chan.pos_y <= s.pos_y;
      in_chan.yaw <= s.yaw;
      in_chan.valid <= 1'b1;
      send_busy = 1'b1;
      send_gap = $urandom_range(0, 3);
    end else begin
      in_chan.valid <= 1'b0;
      send_busy = 1'b0;
    end
  end

  // Receiver ready: random stalls per result, plus a long hold-off when asked.
  int recv_gap = 0;
  always @(negedge clk) begin
    if (hold_off || !rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (out_taken) begin
      recv_gap = $urandom_range(0, 3);
      out_chan.ready <= (recv_gap == 0);
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_chan.ready <= (recv_gap == 0);
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  // Monitor: predict on each input transfer, check on each output transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      idle_cycles++;
      if (in_chan.valid && in_chan.ready) begin
        odom_t s;
        s.pos_x = in_chan.pos_x;
        s.pos_y = in_chan.pos_y;
        s.yaw = in_chan.yaw;
        command_q.push_back(predict_command(s));
        idle_cycles = 0;
      end
      if (out_chan.valid && out_chan.ready) begin
        idle_cycles = 0;
        if (command_q.size() == 0) begin
          $error("unexpected command transfer");
          fail_count++;
        end else begin
          command_t e;
          e = command_q.pop_front();
          if (out_chan.lin_vel !== e.lin_vel) begin
            $error("lin_vel expected %0d got %0d", e.lin_vel, out_chan.lin_vel);
            fail_count++;
          end
          if (out_chan.ang_vel !== e.ang_vel) begin
            $error("ang_vel expected %0d got %0d", e.ang_vel, out_chan.ang_vel);
            fail_count++;
          end
          if (out_chan.distance !== e.distance) begin
            $error("distance expected %0d got %0d", e.distance, out_chan.distance);
            fail_count++;
          end
          if (out_chan.alpha !== e.alpha) begin
            $error("alpha expected %0d got %0d", e.alpha, out_chan.alpha);
            fail_count++;
          end
          if (out_chan.bearing !== e.bearing) begin
            $error("bearing expected %0d got %0d", e.bearing, out_chan.bearing);
            fail_count++;
          end
          if (out_chan.waypoint_used !== e.waypoint_used) begin
            $error("waypoint_used expected %0d got %0d", e.waypoint_used,
                   out_chan.waypoint_used);
            fail_count++;
          end
          if (out_chan.arrived !== e.arrived) begin
            $error("arrived expected %0d got %0d", e.arrived, out_chan.arrived);
            fail_count++;
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[polar_pose_control_waypoints] ERROR");
        $finish;
      end
    end
  end

  // Write one register at a falling edge; mirror it in the shadow copy.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx < REG_K1) wp_reg[idx] = val;
    else if (idx == REG_K1) k_dist = val[15:0];
    else if (idx == REG_K2) k_alpha = val[15:0];
    else if (idx == REG_K3) k_beta = val[15:0];
    else arrive_thr = val[15:0];
  endtask

  // Wait until all queued samples are sent and every command has come back.
  task automatic drain();
    wait (sample_q.size() == 0 && !send_busy);
    while (command_q.size() != 0 || in_chan.valid) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic odom_t rand_sample();
    odom_t s;
    s.pos_x = 16'($urandom);
    s.pos_y = 16'($urandom);
    s.yaw = 15'($signed($urandom_range(0, 25736)) - 12868);
    return s;
  endfunction

  // Sample close to the origin, so with small waypoint offsets arrivals happen often.
  function automatic odom_t near_sample(int spread);
    odom_t s;
    s.pos_x = 16'($signed($urandom_range(0, 2 * spread)) - spread);
    s.pos_y = 16'($signed($urandom_range(0, 2 * spread)) - spread);
    s.yaw = 15'($signed($urandom_range(0, 25736)) - 12868);
    return s;
  endfunction

  task automatic push(input logic signed [15:0] px, input logic signed [15:0] py,
                      input logic signed [14:0] yw);
    odom_t s;
    s.pos_x = px; s.pos_y = py; s.yaw = yw;
    sample_q.push_back(s);
  endtask

  initial begin
    wp_reg[0] = 32'hFF000000; wp_reg[1] = 32'hFE000000;
    wp_reg[2] = 32'hFD000000; wp_reg[3] = 32'hFC000000;
    k_dist = 16'd1024; k_alpha = 16'd3686; k_beta = 16'hFB33;
    arrive_thr = 16'd8; wp_index = 2'd0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: arrive at each reset waypoint, origin, field extremes.
    push(16'sd256, 16'sd0, 15'sd0);
    push(16'sd512, 16'sd0, 15'sd12868);
    push(16'sd768, 16'sd3, -15'sd12868);
    push(16'sd1024, 16'sd0, 15'sd0);
    push(16'sd32767, 16'sd32767, 15'sd12868);
    push(-16'sd32768, -16'sd32768, -15'sd12868);
    push(16'sd32767, -16'sd32768, 15'sd0);
    push(-16'sd32768, 16'sd32767, 15'sd100);
    push(16'sd0, 16'sd100, 15'sd0);
    push(16'sd0, -16'sd100, 15'sd0);
    push(16'sd500, 16'sd0, 15'sd0);
    push(-16'sd500, 16'sd0, 15'sd0);
    drain();

    // Extreme gains and threshold, full-scale waypoints.
    write_reg(REG_K1, 32'h00007FFF);
    write_reg(REG_K2, 32'h00008000);
    write_reg(REG_K3, 32'h00007FFF);
    write_reg(REG_THR, 32'h0000FFFF);
    write_reg(REG_WP0, 32'h7FFF7FFF);
    write_reg(REG_WP1, 32'h80008000);
    write_reg(REG_WP2, 32'h7FFF8000);
    write_reg(REG_WP3, 32'h80007FFF);
    push(16'sd32767, 16'sd32767, 15'sd12868);
    push(-16'sd32768, -16'sd32768, -15'sd12868);
    push(16'sd0, 16'sd0, 15'sd0);
    push(16'sd1, -16'sd1, 15'sd1);
    push(16'sd0, 16'sd0, 15'sd0);
    drain();

    write_reg(REG_THR, 32'h00000000);
    push(16'sd0, 16'sd0, 15'sd0);
    push(-16'sd32768, 16'sd32767, 15'sd12868);
    drain();

    // Pressure: stop the receiver while samples keep coming.
    hold_off = 1'b1;
    for (int i = 0; i < 20; i++) sample_q.push_back(rand_sample());
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
    drain();

    // Random phases with several settings.
    for (int phase = 0; phase < 8; phase++) begin
      for (int r = 0; r < 8; r++) write_reg(3'(r), $urandom);
      if (phase % 2 == 0) begin
        // small offsets and a sizeable threshold: some samples reach targets
        for (int r = 0; r < 4; r++)
          write_reg(3'(r), {16'($signed($urandom_range(0, 2048)) - 1024),
                            16'($signed($urandom_range(0, 2048)) - 1024)});
        write_reg(REG_THR, 32'($urandom_range(64, 1024)));
        write_reg(REG_K1, 32'($urandom_range(0, 8192)));
      end
      for (int i = 0; i < 125; i++) begin
        if ($urandom_range(0, 3) != 0) sample_q.push_back(near_sample(1200));
        else sample_q.push_back(rand_sample());
      end
      drain();
    end

    wait (idle_cycles >= 0);
    if (fail_count == 0) $display("[polar_pose_control_waypoints] OK");
    else $display("[polar_pose_control_waypoints] ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/ppcw_pkg.sv
design/ppcw_if.sv
design/ppcw_cordic.sv
design/ppcw_norm.sv
design/ppcw_mac.sv
design/polar_pose_control_waypoints.sv
tb/tb_polar_pose_control_waypoints.sv
